### hw/rtl/sot_pkg.sv
// Shared widths and controller state codes for the segment overlap trimmer.
package sot_pkg;

  // Fixed field widths.
  localparam int POS_W   = 32;
  localparam int SCORE_W = 25;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_ENDS   = 9'b000000010,
    ST_DECIDE = 9'b000000100,
    ST_MUL    = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_FIX    = 9'b000100000,
    ST_EMIT_H = 9'b001000000,
    ST_COMMIT = 9'b010000000,
    ST_EMIT_N = 9'b100000000
  } sot_state_t;

endpackage

### hw/rtl/segment_overlap_trimmer_top.sv
// Top level of the segment overlap trimmer: pair check, bit-serial rescale and output register.

// The block reads a list of alignment segments, one per request, keeps the previous
// segment and trims overlaps between it and the new one on the query axis. A held
// segment leaves when the next one arrives; the request marked tlast is flushed right
// after its predecessor, with tlast set on the result. Items are taken one at a time.
// A pair where one segment is shortened goes through the shift-add multiplier (one bit
// of the new length per cycle) and the restoring divider (one quotient bit per cycle
// for the 25 score bits) that rescale the score. A last item adds the flush step
// ST_EMIT_N. A stalled result holds the block only when the next result is ready to
// leave; the output register lets the next request in.
module segment_overlap_trimmer_top
  import sot_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  // Input segments.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: query_start, target_start, seg_length, seg_score, strand_plus.
  input  logic [((2 * POS_W + LENGTH_BITS + SCORE_W + 8) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                s_axis_tlast,   // last_in_list
  // Trimmed segments.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: out_query_start, out_target_start, out_length, out_score,
  // out_strand_plus, out_trimmed.
  output logic [((2 * POS_W + LENGTH_BITS + SCORE_W + 9) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                m_axis_tlast    // out_last
);

  localparam int LB        = LENGTH_BITS;
  localparam int IN_BITS   = 2 * POS_W + LB + SCORE_W + 1;
  localparam int OUT_BITS  = IN_BITS + 1;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int TS_LO     = POS_W;
  localparam int LEN_LO    = 2 * POS_W;
  localparam int SCORE_LO  = LEN_LO + LB;
  localparam int STRAND_B  = SCORE_LO + SCORE_W;
  localparam int STEPS_MAX = (LB > SCORE_W) ? LB : SCORE_W;
  localparam int CNT_W     = $clog2(STEPS_MAX);
  localparam int WORK_W    = LB + SCORE_W + 1;
  localparam int PROD_W    = LB + SCORE_W;

  sot_state_t state;

  // Held segment.
  logic                      held_valid;
  logic [POS_W-1:0]          h_qs, h_ts;
  logic [LB-1:0]             h_len;
  logic signed [SCORE_W-1:0] h_score;
  logic                      h_strand, h_trim;

  // Newly accepted segment.
  logic [POS_W-1:0]          n_qs, n_ts;
  logic [LB-1:0]             n_len;
  logic signed [SCORE_W-1:0] n_score;
  logic                      n_strand, n_trim, n_last;

  // Query end positions, computed without wrap.
  logic [POS_W:0]            eh, en;

  // Rescale unit.
  logic                      sh_new;
  logic [LB-1:0]             sh_nl, sh_len;
  logic                      sh_neg;
  logic [SCORE_W-1:0]        sh_mag;
  logic [WORK_W-1:0]         work;
  logic [LB-1:0]             rem;
  logic [SCORE_W-1:0]        qsr;
  logic [CNT_W-1:0]          cnt;

  // Pair classification.
  logic h_nz, n_nz, h_in_n, n_in_h, drop_h, drop_n, past_h, trim_h, trim_n;
  always_comb begin
    h_nz   = (h_len != '0);
    n_nz   = (n_len != '0);
    h_in_n = h_nz && n_nz && (h_qs >= n_qs) && (eh <= en);
    n_in_h = h_nz && n_nz && (n_qs >= h_qs) && (en <= eh);
    drop_h = !h_nz || h_in_n;
    drop_n = !n_nz || n_in_h;
    past_h = ({1'b0, n_qs} > eh);
    trim_h = (h_qs < n_qs);
    trim_n = (n_qs < h_qs) && ({1'b0, h_qs} <= en);
  end

  // Shorten target values picked in the decide step.
  logic [LB-1:0]             pick_nl, pick_len;
  logic signed [SCORE_W-1:0] pick_score;
  always_comb begin
    if (trim_h) begin
      pick_nl    = LB'(n_qs - h_qs);
      pick_len   = h_len;
      pick_score = h_score;
    end else begin
      pick_nl    = LB'(h_qs - n_qs);
      pick_len   = n_len;
      pick_score = n_score;
    end
  end

  // One shift-add multiply step and one restoring divide step.
  logic [SCORE_W:0]          mul_sum;
  logic [WORK_W-1:0]         work_next;
  logic [LB:0]               div_t;
  logic                      div_ge;
  logic [LB:0]               div_diff;
  logic signed [SCORE_W-1:0] res_score;
  always_comb begin
    mul_sum   = work[WORK_W-1:LB] + (work[0] ? {1'b0, sh_mag} : '0);
    work_next = {mul_sum, work[LB-1:0]} >> 1;
    div_t     = {rem, qsr[SCORE_W-1]};
    div_ge    = (div_t >= {1'b0, sh_len});
    div_diff  = div_t - {1'b0, sh_len};
    res_score = sh_neg ? -$signed(qsr) : $signed(qsr);
  end

  logic out_free;
  logic out_load;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = ((state == ST_EMIT_H) || (state == ST_EMIT_N)) && out_free;
  assign s_axis_tready = (state == ST_IDLE);

  // Controller and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Output valid: a new result takes priority over clearing the one just taken.
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            n_qs     <= s_axis_tdata[TS_LO-1:0];
            n_ts     <= s_axis_tdata[LEN_LO-1:TS_LO];
            n_len    <= s_axis_tdata[SCORE_LO-1:LEN_LO];
            n_score  <= $signed(s_axis_tdata[STRAND_B-1:SCORE_LO]);
            n_strand <= s_axis_tdata[STRAND_B];
            n_trim   <= 1'b0;
            n_last   <= s_axis_tlast;
            state    <= ST_ENDS;
          end
        end
        ST_ENDS: begin
          eh <= {1'b0, h_qs} + (POS_W + 1)'(h_len) - (POS_W + 1)'(1);
          en <= {1'b0, n_qs} + (POS_W + 1)'(n_len) - (POS_W + 1)'(1);
          state <= held_valid ? ST_DECIDE : ST_COMMIT;
        end
        ST_DECIDE: begin
          priority if (drop_h) begin
            h_len <= '0;
            state <= ST_EMIT_H;
          end else if (drop_n) begin
            n_len <= '0;
            state <= ST_EMIT_H;
          end else if (past_h) begin
            state <= ST_EMIT_H;
          end else if (trim_h || trim_n) begin
            sh_new <= !trim_h;
            sh_nl  <= pick_nl;
            sh_len <= pick_len;
            sh_neg <= pick_score[SCORE_W-1];
            sh_mag <= pick_score[SCORE_W-1] ? SCORE_W'(-pick_score) : SCORE_W'(pick_score);
            work   <= {{(SCORE_W + 1){1'b0}}, pick_nl};
            cnt    <= CNT_W'(LB - 1);
            state  <= ST_MUL;
          end else begin
            state <= ST_EMIT_H;
          end
        end
        ST_MUL: begin
          work <= work_next;
          if (cnt == '0) begin
            // Product's top bits start the remainder, the rest feed the divider.
            rem   <= work_next[PROD_W-1:SCORE_W];
            qsr   <= work_next[SCORE_W-1:0];
            cnt   <= CNT_W'(SCORE_W - 1);
            state <= ST_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DIV: begin
          rem <= div_ge ? div_diff[LB-1:0] : div_t[LB-1:0];
          qsr <= {qsr[SCORE_W-2:0], div_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (sh_new) begin
            n_len   <= sh_nl;
            n_score <= res_score;
            n_trim  <= 1'b1;
          end else begin
            h_len   <= sh_nl;
            h_score <= res_score;
            h_trim  <= 1'b1;
          end
          state <= ST_EMIT_H;
        end
        ST_EMIT_H: begin
          if (out_free) begin
            m_axis_tlast  <= 1'b0;
            m_axis_tdata  <= OUT_W'({h_trim, h_strand, h_score, h_len, h_ts, h_qs});
            state         <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          h_qs       <= n_qs;
          h_ts       <= n_ts;
          h_len      <= n_len;
          h_score    <= n_score;
          h_strand   <= n_strand;
          h_trim     <= n_trim;
          held_valid <= !n_last;
          state      <= n_last ? ST_EMIT_N : ST_IDLE;
        end
        ST_EMIT_N: begin
          if (out_free) begin
            m_axis_tlast  <= 1'b1;
            m_axis_tdata  <= OUT_W'({n_trim, n_strand, n_score, n_len, n_ts, n_qs});
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The divider remainder always stays below the divisor.
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> (rem < sh_len))
    else $error("divider remainder reached the divisor");

  // A shortened length is nonzero and below the old length.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> ((sh_nl != '0) && (sh_nl < sh_len)))
    else $error("shortened length out of range");

  // A rescaled score never grows in magnitude.
  assert property (@(posedge clk) disable iff (rst) (state == ST_FIX) |-> (qsr <= sh_mag))
    else $error("rescaled score grew");

  // After a flush nothing is left held.
  assert property (@(posedge clk) disable iff (rst) (state == ST_EMIT_N) |-> !held_valid)
    else $error("segment still held during flush");

endmodule

### bench/tb_segment_overlap_trimmer_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the segment overlap trimmer: directed table, random lists, scoreboard.
module tb_segment_overlap_trimmer_top
  import sot_pkg::*;
();

  // Field layout of the stream buses, lowest field first.
  localparam int LEN_W      = 24;
  localparam int IN_BITS    = 2 * POS_W + LEN_W + SCORE_W + 1;
  localparam int OUT_BITS   = IN_BITS + 1;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
  localparam int LEN_LO     = 2 * POS_W;
  localparam int SCORE_LO   = LEN_LO + LEN_W;
  localparam int STRAND_BIT = SCORE_LO + SCORE_W;
  localparam int TRIM_BIT   = STRAND_BIT + 1;

  // Run shape.
  localparam int SCORE_MAX    = 16777215;
  localparam int ITEM_TARGET  = 1050;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_AT     = 300;
  localparam int STALL_CYCLES = 400;
  localparam int PAUSE_AT     = 700;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_N        = 23;

  typedef struct packed {
    logic [POS_W-1:0]          qs;
    logic [POS_W-1:0]          ts;
    logic [LEN_W-1:0]          len;
    logic signed [SCORE_W-1:0] score;
    logic                      strand;
    logic                      last;
  } seg_req_t;

  typedef struct {
    logic [POS_W-1:0]          qs;
    logic [POS_W-1:0]          ts;
    logic [LEN_W-1:0]          len;
    logic signed [SCORE_W-1:0] score;
    logic                      strand;
    logic                      trimmed;
    logic                      last;
  } seg_res_t;

  typedef struct packed {
    logic     typed;
    seg_req_t req;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // Fields from bit 0: query_start, target_start, seg_length, seg_score, strand_plus.
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;   // last_in_list
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // Fields from bit 0: out_query_start, out_target_start, out_length, out_score,
  // out_strand_plus, out_trimmed.
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;          // out_last

  segment_overlap_trimmer_top #(
    .LENGTH_BITS(LEN_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // Segments still owed by the block, oldest first.
  seg_res_t segs_due[$];

  // Predictor copy of the held segment.
  bit                     keep_valid;
  logic [POS_W-1:0]       keep_qs;
  logic [POS_W-1:0]       keep_ts;
  longint unsigned        keep_len;
  longint signed          keep_score;
  logic                   keep_strand;
  bit                     keep_trim;

  int  in_count;
  int  lists_done;
  int  res_count;
  int  trim_count;
  int  drop_count;
  int  errors;
  bit  idle_off;
  bit  paused;
  bit  stall_done;
  seg_res_t got;
  seg_res_t want;

  // Directed rows: extremes, every pair rule, empty segments and single-item lists.
  dir_row_t dir_rows [0:DIR_N-1] = '{
    '{1'b1, '{32'h0, 32'h0, 24'h0, 25'sd0, 1'b0, 1'b1}},
    '{1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 25'sd16777215, 1'b1, 1'b1}},
    '{1'b1, '{32'h0, 32'hFFFFFFFF, 24'h1, -25'sd16777215, 1'b1, 1'b1}},
    '{1'b0, '{32'd100, 32'h1000, 24'd50, 25'sd1000, 1'b1, 1'b0}},
    '{1'b0, '{32'd90, 32'h2000, 24'd100, -25'sd2000, 1'b0, 1'b0}},
    '{1'b0, '{32'd100, 32'h3000, 24'd10, 25'sd77, 1'b1, 1'b0}},
    '{1'b0, '{32'd500, 32'h4000, 24'd100, -25'sd777, 1'b1, 1'b0}},
    '{1'b0, '{32'd550, 32'h5000, 24'd100, 25'sd999, 1'b0, 1'b0}},
    '{1'b0, '{32'd520, 32'h6000, 24'd60, 25'sd12345, 1'b1, 1'b0}},
    '{1'b0, '{32'd5000, 32'h7000, 24'd10, 25'sd3, 1'b0, 1'b0}},
    '{1'b0, '{32'd100, 32'h8000, 24'd10, 25'sd5, 1'b1, 1'b1}},
    '{1'b0, '{32'd1000, 32'h9000, 24'd20, 25'sd50, 1'b0, 1'b0}},
    '{1'b0, '{32'd1000, 32'hA000, 24'd0, 25'sd7, 1'b1, 1'b0}},
    '{1'b0, '{32'd1000, 32'hB000, 24'd0, -25'sd9, 1'b0, 1'b1}},
    '{1'b0, '{32'hFFFFFF00, 32'hC000, 24'hFFFFFF, -25'sd16777215, 1'b1, 1'b0}},
    '{1'b0, '{32'hFFFFFFF0, 32'hD000, 24'hFFFFFF, 25'sd16777215, 1'b0, 1'b1}},
    '{1'b0, '{32'h0, 32'hE000, 24'hFFFFFF, 25'sd16777215, 1'b1, 1'b0}},
    '{1'b0, '{32'h1, 32'hF000, 24'hFFFFFF, -25'sd16777215, 1'b0, 1'b1}},
    '{1'b0, '{32'd300, 32'h10000, 24'd10, 25'sd40, 1'b1, 1'b0}},
    '{1'b0, '{32'd300, 32'h11000, 24'd20, 25'sd41, 1'b0, 1'b1}},
    '{1'b0, '{32'd300, 32'h12000, 24'd20, 25'sd42, 1'b1, 1'b0}},
    '{1'b0, '{32'd300, 32'h13000, 24'd20, -25'sd43, 1'b0, 1'b1}},
    '{1'b1, '{32'd7, 32'hFFFFFFFF, 24'h0, 25'sd0, 1'b1, 1'b1}}
  };

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overall time limit.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random score spread over the whole legal range.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    int v;
    v = int'($urandom_range(0, 2 * SCORE_MAX)) - SCORE_MAX;
    return v[SCORE_W-1:0];
  endfunction

  // True when segment a lies within segment b; empty segments never qualify.
  function automatic bit covers(longint unsigned aq, longint unsigned al,
                                longint unsigned bq, longint unsigned bl);
    if (al == 0 || bl == 0) return 1'b0;
    return aq >= bq && aq + al - 1 <= bq + bl - 1;
  endfunction

  // Pair trim of the held and new segment; queues the segments this request releases.
  task automatic trim_and_emit(input seg_req_t r);
    longint unsigned hl, nl, nq, eh, en, ov;
    longint signed   hs, ns;
    bit              ht, nt;
    seg_res_t        res;
    nq = r.qs;
    nl = r.len;
    ns = r.score;
    nt = 1'b0;
    if (keep_valid) begin
      hl = keep_len;
      hs = keep_score;
      ht = keep_trim;
      if (hl == 0 || covers(keep_qs, hl, nq, nl)) begin
        hl = 0;
      end else if (nl == 0 || covers(nq, nl, keep_qs, hl)) begin
        nl = 0;
      end else begin
        eh = keep_qs + hl - 1;
        en = nq + nl - 1;
        if (nq > eh) begin
          // Disjoint, new one after the held one: untouched.
        end else if (keep_qs < nq) begin
          ov = eh - nq + 1;
          hs = ($signed(hl - ov) * hs) / $signed(hl);
          hl = hl - ov;
          ht = 1'b1;
        end else if (nq < keep_qs && keep_qs <= en) begin
          ov = en - keep_qs + 1;
          ns = ($signed(nl - ov) * ns) / $signed(nl);
          nl = nl - ov;
          nt = 1'b1;
        end
      end
      res.qs      = keep_qs;
      res.ts      = keep_ts;
      res.len     = hl[LEN_W-1:0];
      res.score   = hs[SCORE_W-1:0];
      res.strand  = keep_strand;
      res.trimmed = ht;
      res.last    = 1'b0;
      segs_due.push_back(res);
    end
    keep_qs     = r.qs;
    keep_ts     = r.ts;
    keep_len    = nl;
    keep_score  = ns;
    keep_strand = r.strand;
    keep_trim   = nt;
    if (r.last) begin
      res.qs      = r.qs;
      res.ts      = r.ts;
      res.len     = nl[LEN_W-1:0];
      res.score   = ns[SCORE_W-1:0];
      res.strand  = r.strand;
      res.trimmed = nt;
      res.last    = 1'b1;
      segs_due.push_back(res);
      keep_valid = 1'b0;
    end else begin
      keep_valid = 1'b1;
    end
  endtask

  // Offer one request and wait for its handshake. A typed row carries its own expectation.
  task automatic send_seg(input seg_req_t r, input bit typed);
    int       gap;
    seg_res_t res;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, r.strand, r.score, r.len, r.ts, r.qs};
    s_axis_tlast  <= r.last;
    do @(posedge clk); while (!s_axis_tready);
    in_count++;
    if (r.last) lists_done++;
    if (typed) begin
      // Single-item list: the segment comes back unchanged with the last flag.
      res.qs      = r.qs;
      res.ts      = r.ts;
      res.len     = r.len;
      res.score   = r.score;
      res.strand  = r.strand;
      res.trimmed = 1'b0;
      res.last    = 1'b1;
      segs_due.push_back(res);
    end else begin
      trim_and_emit(r);
    end
  endtask

  // Wait until every owed segment has come out.
  task automatic wait_drained();
    do @(posedge clk); while (segs_due.size() != 0);
  endtask

  // One random list: mostly chained overlapping segments, some pure noise.
  task automatic send_random_list();
    int              n, i, r;
    bit              noise;
    seg_req_t        s;
    longint unsigned q, plen;
    longint signed   off;
    noise    = ($urandom_range(0, 99) < 15);
    idle_off = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 9);
    n = (r < 2) ? 1 : (r < 7) ? $urandom_range(2, 4) : $urandom_range(5, 8);
    q = ($urandom_range(0, 7) == 0) ? 64'hFFFFFFFF - $urandom_range(0, 2000) : $urandom;
    plen = 0;
    for (i = 0; i < n; i++) begin
      if (noise) begin
        s.qs  = $urandom;
        s.len = LEN_W'($urandom);
        s.last = (i == n - 1) || ($urandom_range(0, 3) == 0);
      end else begin
        if (i > 0) begin
          off = longint'($urandom_range(0, 32'(plen) + 16)) - longint'(plen / 2);
          q = (q + off) & 64'hFFFFFFFF;
        end
        r = $urandom_range(0, 99);
        if (r < 6) s.len = '0;
        else if (r < 10) s.len = LEN_W'($urandom);
        else if (r < 20) s.len = LEN_W'($urandom_range(1, 65535));
        else s.len = LEN_W'($urandom_range(1, 300));
        s.qs = q[POS_W-1:0];
        s.last = (i == n - 1);
      end
      plen = s.len;
      s.ts = $urandom;
      s.score = rand_score();
      s.strand = 1'($urandom_range(0, 1));
      send_seg(s, 1'b0);
      if (s.last && i != n - 1) break;
    end
  endtask

  // Sender: reset, directed table, random lists, drain and verdict.
  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < DIR_N; i++) send_seg(dir_rows[i].req, dir_rows[i].typed);
    while (in_count < ITEM_TARGET) begin
      if (!paused && in_count >= PAUSE_AT) begin
        // Let the block run dry before going on.
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      send_random_list();
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d segments in %0d lists; checked %0d results, %0d trimmed, %0d removed.",
             in_count, lists_done, res_count, trim_count, drop_count);
    $display("Pair rules, empty and extreme segments, a long output stall and a full drain.");
    if (errors == 0 && segs_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("Failures: %0d, segments still owed: %0d", errors, segs_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver ready: random gaps and bursts, plus one long hold-off.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (!stall_done && in_count >= STALL_AT) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12))
          @(posedge clk);
      end
    end
  end

  // Failure bookkeeping: the first few are shown in full.
  task automatic note_fail(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("%s", msg);
  endtask

  // Scoreboard: each accepted result against the oldest owed segment.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.qs      = m_axis_tdata[POS_W-1:0];
      got.ts      = m_axis_tdata[POS_W +: POS_W];
      got.len     = m_axis_tdata[LEN_LO +: LEN_W];
      got.score   = m_axis_tdata[SCORE_LO +: SCORE_W];
      got.strand  = m_axis_tdata[STRAND_BIT];
      got.trimmed = m_axis_tdata[TRIM_BIT];
      got.last    = m_axis_tlast;
      res_count++;
      if (got.trimmed) trim_count++;
      if (got.len == 0) drop_count++;
      if (segs_due.size() == 0) begin
        note_fail($sformatf("Unexpected result %0d: qs=%h len=%h", res_count, got.qs, got.len));
      end else begin
        want = segs_due.pop_front();
        if (got.qs !== want.qs || got.ts !== want.ts || got.len !== want.len ||
            got.score !== want.score || got.strand !== want.strand ||
            got.trimmed !== want.trimmed || got.last !== want.last) begin
          note_fail($sformatf(
            {"Result %0d mismatch: exp qs=%h ts=%h len=%h score=%0d st=%b tr=%b last=%b, ",
             "got qs=%h ts=%h len=%h score=%0d st=%b tr=%b last=%b"},
            res_count, want.qs, want.ts, want.len, want.score, want.strand, want.trimmed,
            want.last, got.qs, got.ts, got.len, got.score, got.strand, got.trimmed,
            got.last));
        end
      end
    end
  end

endmodule
